// File: rtl/core/smrc_pkg.sv
// shared types and constants of the small risc step engine
package smrc_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned REG_CNT    = 17;
  localparam int unsigned REG_IDX_W  = 5;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned KIND_W     = 2;

  localparam logic [REG_IDX_W-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_IDX_W-1:0] REG_LINK = 5'd16;
  localparam logic [REG_IDX_W-1:0] REG_LAST = 5'd16;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // transaction kinds on the input stream
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE_MEM = 2'd0,
    KIND_STEP      = 2'd1,
    KIND_READ_MEM  = 2'd2,
    KIND_READ_REG  = 2'd3
  } kind_e;

  // instruction opcodes, bits 15..12
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_ADDI  = 4'd2,
    OP_SHIFT = 4'd3,
    OP_AND   = 4'd4,
    OP_OR    = 4'd5,
    OP_XOR   = 4'd6,
    OP_NOT   = 4'd7,
    OP_SLT   = 4'd8,
    OP_LOAD  = 4'd9,
    OP_STORE = 4'd10,
    OP_LUI   = 4'd11,
    OP_BEQ   = 4'd12,
    OP_BLT   = 4'd13,
    OP_JUMP  = 4'd14,
    OP_JAL   = 4'd15
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_EXEC,
    ST_LOAD,
    ST_STORE,
    ST_DONE
  } state_e;

  // execute unit outcome
  typedef struct packed {
    logic     wr_en;
    reg_idx_t dst;
    word_t    value;
    word_t    next_pc;
    logic     load;
    logic     store;
    word_t    ls_addr;
  } alu_res_t;

  // result item, pc_now in the lowest bits
  typedef struct packed {
    word_t    read_data;
    logic     mem_written;
    word_t    reg_value;
    reg_idx_t reg_number;
    logic     reg_written;
    logic     halted;
    word_t    instruction;
    word_t    pc_now;
  } result_t;

endpackage

// File: rtl/core/smrc_wmem.sv
// shared word memory, one write port and one registered read port
module smrc_wmem #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MEM_WORDS)-1:0] waddr_i,
  input  smrc_pkg::word_t              wdata_i,
  input  logic [$clog2(MEM_WORDS)-1:0] raddr_i,
  output smrc_pkg::word_t              rdata_o
);
  import smrc_pkg::*;

  word_t mem_q [MEM_WORDS];
  word_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/smrc_regfile.sv
// register file, two registered read ports, per-entry valid bits for reset
module smrc_regfile (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  smrc_pkg::reg_idx_t waddr_i,
  input  smrc_pkg::word_t    wdata_i,
  input  smrc_pkg::reg_idx_t raddr_a_i,
  input  smrc_pkg::reg_idx_t raddr_b_i,
  output smrc_pkg::word_t    rdata_a_o,
  output smrc_pkg::word_t    rdata_b_o
);
  import smrc_pkg::*;

  word_t              regs_q [REG_CNT];
  logic [REG_CNT-1:0] valid_q;
  word_t              rdata_a_q;
  word_t              rdata_b_q;
  logic               hit_a_q;
  logic               hit_b_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      regs_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= regs_q[raddr_a_i];
    rdata_b_q <= regs_q[raddr_b_i];
  end

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      hit_a_q <= (raddr_a_i <= REG_LAST) && valid_q[raddr_a_i];
      hit_b_q <= (raddr_b_i <= REG_LAST) && valid_q[raddr_b_i];
    end
  end

  assign rdata_a_o = hit_a_q ? rdata_a_q : '0;
  assign rdata_b_o = hit_b_q ? rdata_b_q : '0;

endmodule

// File: rtl/core/smrc_alu.sv
// instruction decode and execute for one step
module smrc_alu (
  input  smrc_pkg::word_t    ir_i,
  input  smrc_pkg::word_t    a_i,
  input  smrc_pkg::word_t    b_i,
  input  smrc_pkg::word_t    pc_i,
  output smrc_pkg::alu_res_t res_o
);
  import smrc_pkg::*;

  op_e      op;
  reg_idx_t rs;
  reg_idx_t rd;
  word_t    c4;
  word_t    c8;
  word_t    sum_ab;
  word_t    sum_c8;
  logic     lt;
  logic [7:0] neg_amt;
  logic [3:0] rsh_amt;
  word_t    shifted;
  alu_res_t res;

  // field decode
  assign op     = op_e'(ir_i[15:12]);
  assign rs     = {1'b0, ir_i[11:8]};
  assign rd     = {1'b0, ir_i[3:0]};
  assign c4     = {{12{ir_i[3]}}, ir_i[3:0]};
  assign c8     = {{8{ir_i[7]}}, ir_i[7:0]};
  assign sum_ab = a_i + b_i;
  assign sum_c8 = a_i + c8;
  assign lt     = $signed(a_i) < $signed(b_i);

  // shift: negative constant shifts left, else arithmetic right
  assign neg_amt = 8'(~ir_i[7:0] + 8'd1);
  assign rsh_amt = (ir_i[7:0] >= 8'd15) ? 4'd15 : ir_i[3:0];
  always_comb begin
    if (ir_i[7]) begin
      shifted = (neg_amt >= 8'd16) ? '0 : (a_i << neg_amt[3:0]);
    end else begin
      shifted = word_t'($signed(a_i) >>> rsh_amt);
    end
  end

  // operation select
  always_comb begin
    res         = '0;
    res.wr_en   = 1'b1;
    res.dst     = rd;
    res.next_pc = pc_i;
    res.ls_addr = sum_ab;
    case (op)
      OP_ADD:   res.value = sum_ab;
      OP_SUB:   res.value = a_i - b_i;
      OP_ADDI: begin
        res.dst   = rs;
        res.value = sum_c8;
      end
      OP_SHIFT: begin
        res.dst   = rs;
        res.value = shifted;
      end
      OP_AND:   res.value = a_i & b_i;
      OP_OR:    res.value = a_i | b_i;
      OP_XOR:   res.value = a_i ^ b_i;
      OP_NOT: begin
        res.dst   = rs;
        res.value = ~a_i;
      end
      OP_SLT:   res.value = {15'd0, lt};
      OP_LOAD:  res.load = 1'b1;
      OP_STORE: begin
        res.wr_en = 1'b0;
        res.store = 1'b1;
      end
      OP_LUI: begin
        res.dst   = rs;
        res.value = {ir_i[7:0], 8'd0};
      end
      OP_BEQ: begin
        res.wr_en = 1'b0;
        if (a_i == b_i) begin
          res.next_pc = pc_i + c4;
        end
      end
      OP_BLT: begin
        res.wr_en = 1'b0;
        if (lt) begin
          res.next_pc = pc_i + c4;
        end
      end
      OP_JUMP: begin
        res.wr_en   = 1'b0;
        res.next_pc = sum_c8;
      end
      OP_JAL: begin
        res.dst     = REG_LINK;
        res.value   = pc_i;
        res.next_pc = sum_c8;
      end
      default: res.wr_en = 1'b0;
    endcase
    // register zero is never written
    if (res.dst == REG_ZERO) begin
      res.wr_en = 1'b0;
    end
  end

  assign res_o = res;

endmodule

// File: rtl/core/small_risc_cpu_step.sv
// top level: sequencer around the word memory and register file
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o tuser kind, tdata address/data/reg_index
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata result fields
//
// after reset the memory is cleared one word a cycle, input held off.
// write-memory goes straight to DONE, read-memory and read-register pass READ, a step FETCH
// and EXEC, a load or store also LOAD or STORE, the step fetching the zero word only FETCH,
// a step after halt none; each step waits on the registered memory and register file reads.
// one item is in the sequencer at a time; the next is taken while a result waits in the
// output register, and the sequencer stalls only when it must hand over a second result.
module small_risc_cpu_step #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // address[15:0], data[31:16], reg_index[36:32], zero pad[39:37]
  input  logic [smrc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // kind[1:0]
  input  logic [smrc_pkg::KIND_W-1:0]      s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // pc_now[15:0], instruction[31:16], halted[32], reg_written[33], reg_number[38:34],
  // reg_value[54:39], mem_written[55], read_data[71:56]
  output logic [smrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import smrc_pkg::*;

  localparam int unsigned     AW       = $clog2(MEM_WORDS);
  localparam logic [31:0]     MEM_W32  = 32'(MEM_WORDS);
  localparam bit              IS_POW2  = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  localparam logic [AW-1:0]   CLR_LAST = AW'(MEM_WORDS - 1);

  // word address modulo the memory size
  function automatic logic [AW-1:0] mem_idx(input word_t a);
    logic [31:0] r;
    r = {16'd0, a};
    for (int k = 7; k >= 0; k--) begin
      if (!IS_POW2 && (r >= (MEM_W32 << k))) begin
        r = r - (MEM_W32 << k);
      end
    end
    return IS_POW2 ? a[AW-1:0] : r[AW-1:0];
  endfunction

  state_e   state_q, state_d;
  logic [AW-1:0] clr_cnt_q;
  word_t    pc_q;
  logic     stopped_q;
  kind_e    kind_q;
  word_t    ir_q;
  alu_res_t alu_q;
  result_t  res_q;
  result_t  out_q;
  logic     out_valid_q;

  kind_e    in_kind;
  word_t    in_address;
  word_t    in_data;
  reg_idx_t in_reg_index;
  logic     accept;
  logic     out_free;
  result_t  res_init;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;
  logic          rf_we;
  reg_idx_t      rf_waddr;
  word_t         rf_wdata;
  reg_idx_t      rf_raddr_a;
  reg_idx_t      rf_raddr_b;
  word_t         rf_a;
  word_t         rf_b;
  alu_res_t      alu;

  // input unpack and handshake
  assign in_kind      = kind_e'(s_axis_tuser_i);
  assign in_address   = s_axis_tdata_i[15:0];
  assign in_data      = s_axis_tdata_i[31:16];
  assign in_reg_index = s_axis_tdata_i[36:32];
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  smrc_wmem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_wmem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  smrc_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (rf_we),
    .waddr_i  (rf_waddr),
    .wdata_i  (rf_wdata),
    .raddr_a_i(rf_raddr_a),
    .raddr_b_i(rf_raddr_b),
    .rdata_a_o(rf_a),
    .rdata_b_o(rf_b)
  );

  smrc_alu u_alu (
    .ir_i (ir_q),
    .a_i  (rf_a),
    .b_i  (rf_b),
    .pc_i (pc_q),
    .res_o(alu)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE, ST_DONE: begin
        if (state_q == ST_DONE && out_free) begin
          state_d = ST_IDLE;
        end
        if (accept) begin
          case (in_kind)
            KIND_WRITE_MEM: state_d = ST_DONE;
            KIND_STEP:      state_d = stopped_q ? ST_DONE : ST_FETCH;
            KIND_READ_MEM:  state_d = ST_READ;
            KIND_READ_REG:  state_d = ST_READ;
            default:        state_d = ST_DONE;
          endcase
        end
      end
      ST_READ:  state_d = ST_DONE;
      ST_FETCH: state_d = (mem_rdata == '0) ? ST_DONE : ST_EXEC;
      ST_EXEC: begin
        if (alu.load) begin
          state_d = ST_LOAD;
        end else if (alu.store) begin
          state_d = ST_STORE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LOAD:  state_d = ST_DONE;
      ST_STORE: state_d = ST_DONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory and register file controls
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt_q;
    mem_wdata  = '0;
    mem_raddr  = mem_idx(pc_q);
    rf_we      = 1'b0;
    rf_waddr   = alu.dst;
    rf_wdata   = alu.value;
    rf_raddr_a = in_reg_index;
    rf_raddr_b = {1'b0, mem_rdata[7:4]};
    case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          case (in_kind)
            KIND_WRITE_MEM: begin
              mem_we    = 1'b1;
              mem_waddr = mem_idx(in_address);
              mem_wdata = in_data;
            end
            KIND_READ_MEM: mem_raddr = mem_idx(in_address);
            default: ;
          endcase
        end
      end
      ST_FETCH: rf_raddr_a = {1'b0, mem_rdata[11:8]};
      ST_EXEC: begin
        if (alu.load) begin
          mem_raddr = mem_idx(alu.ls_addr);
        end else if (alu.store) begin
          rf_raddr_a = {1'b0, ir_q[3:0]};
        end else begin
          rf_we = alu.wr_en;
        end
      end
      ST_LOAD: begin
        rf_we    = alu_q.wr_en;
        rf_waddr = alu_q.dst;
        rf_wdata = mem_rdata;
      end
      ST_STORE: begin
        mem_we    = 1'b1;
        mem_waddr = mem_idx(alu_q.ls_addr);
        mem_wdata = rf_a;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      pc_q        <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == ST_FETCH) begin
        pc_q <= pc_q + 16'd1;
        if (mem_rdata == '0) begin
          stopped_q <= 1'b1;
        end
      end
      if (state_q == ST_EXEC) begin
        pc_q <= alu.next_pc;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // starting result of a new transaction
  always_comb begin
    res_init        = '0;
    res_init.pc_now = pc_q;
    res_init.halted = stopped_q;
  end

  // item, instruction and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_kind;
      res_q  <= res_init;
    end
    case (state_q)
      ST_READ: begin
        res_q.read_data <= (kind_q == KIND_READ_MEM) ? mem_rdata : rf_a;
      end
      ST_FETCH: begin
        ir_q              <= mem_rdata;
        res_q.instruction <= mem_rdata;
        res_q.pc_now      <= pc_q + 16'd1;
        res_q.halted      <= (mem_rdata == '0);
      end
      ST_EXEC: begin
        alu_q             <= alu;
        res_q.pc_now      <= alu.next_pc;
        res_q.reg_written <= alu.wr_en;
        res_q.reg_number  <= alu.wr_en ? alu.dst : REG_ZERO;
        res_q.reg_value   <= (alu.wr_en && !alu.load) ? alu.value : '0;
        res_q.mem_written <= alu.store;
      end
      ST_LOAD: begin
        res_q.reg_value <= alu_q.wr_en ? mem_rdata : '0;
      end
      default: ;
    endcase
    if (state_q == ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // once halted the block stays halted
  a_stay_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("halt flag cleared");

  // no transaction is taken while the memory is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("input taken during memory clear");

  // register zero is never written
  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (rf_waddr != REG_ZERO))
    else $error("write to register zero");

  // memory and register file are never written in the same cycle
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && rf_we))
    else $error("memory and register write together");

  // pc moves only out of fetch or execute
  a_pc_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pc_q) |-> ($past(state_q) == ST_FETCH || $past(state_q) == ST_EXEC))
    else $error("pc changed outside a step");

endmodule

// File: dv/tb_small_risc_cpu_step.sv
// testbench for small_risc_cpu_step: directed table, random programs, self-checking predictor
module tb_small_risc_cpu_step;
  timeunit 1ns;
  timeprecision 1ps;

  import smrc_pkg::*;

  localparam int unsigned MEM_WORDS   = 4096;
  localparam int          ITEM_TARGET = 1650;
  localparam int          PAUSE_AT    = 900;
  localparam int          LONG_HOLD   = 400;
  localparam int          HOLD_AT     = 300;
  localparam int          END_CYCLES  = 20;
  localparam int          CYCLE_LIMIT = 1000000;

  // directed stimulus row, want_* used only when typed is set
  typedef struct {
    kind_e    kind;
    word_t    addr;
    word_t    data;
    reg_idx_t ridx;
    bit       typed;
    word_t    want_pc;
    word_t    want_read;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [KIND_W-1:0]     s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // cpu state as the predictor sees it
  word_t     mdl_mem [MEM_WORDS];
  word_t     mdl_regs [REG_CNT];
  word_t     mdl_pc;
  logic      mdl_halted;

  result_t   cpu_results_due[$];
  stim_row_t dir_tab[$];
  int        mismatch_cnt = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        cycle_cnt = 0;

  small_risc_cpu_step #(
    .MEM_WORDS(MEM_WORDS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // instruction word from opcode and three nibbles
  function automatic word_t enc(op_e op, logic [3:0] f2, logic [3:0] f1, logic [3:0] f0);
    return {op, f2, f1, f0};
  endfunction

  // any nonzero instruction word
  function automatic word_t rand_instr();
    return word_t'($urandom_range(1, 16'hFFFF));
  endfunction

  function automatic stim_row_t stim_row(kind_e kind, word_t addr, word_t data,
                                         reg_idx_t ridx, bit typed, word_t want_pc,
                                         word_t want_read);
    stim_row_t r;
    r.kind      = kind;
    r.addr      = addr;
    r.data      = data;
    r.ridx      = ridx;
    r.typed     = typed;
    r.want_pc   = want_pc;
    r.want_read = want_read;
    return r;
  endfunction

  // executes one transaction on the predictor state and returns the cpu result
  function automatic result_t model_cpu_item(kind_e kind, word_t addr, word_t data,
                                             reg_idx_t ridx);
    result_t    res;
    word_t      ir, a, b, c4, c8w, v, ls;
    int         c8;
    op_e        op;
    logic [3:0] rs, rt, rd;
    logic       wr;
    reg_idx_t   dst;
    res = '0;
    case (kind)
      KIND_WRITE_MEM: mdl_mem[addr % MEM_WORDS] = data;
      KIND_READ_MEM:  res.read_data = mdl_mem[addr % MEM_WORDS];
      KIND_READ_REG:  res.read_data = (ridx <= REG_LAST) ? mdl_regs[ridx] : '0;
      default: begin
        if (!mdl_halted) begin
          ir = mdl_mem[mdl_pc % MEM_WORDS];
          mdl_pc = mdl_pc + 16'd1;
          res.instruction = ir;
          if (ir == '0) begin
            mdl_halted = 1'b1;
          end else begin
            op  = op_e'(ir[15:12]);
            rs  = ir[11:8];
            rt  = ir[7:4];
            rd  = ir[3:0];
            c4  = {{12{ir[3]}}, ir[3:0]};
            c8w = {{8{ir[7]}}, ir[7:0]};
            c8  = int'($signed(c8w));
            a   = mdl_regs[rs];
            b   = mdl_regs[rt];
            ls  = a + b;
            wr  = 1'b1;
            dst = {1'b0, rd};
            v   = '0;
            case (op)
              OP_ADD:  v = a + b;
              OP_SUB:  v = a - b;
              OP_ADDI: begin
                dst = {1'b0, rs};
                v   = a + c8w;
              end
              OP_SHIFT: begin
                dst = {1'b0, rs};
                // negative amount shifts left, else arithmetic right
                if (c8 < 0) begin
                  v = (-c8 >= 16) ? '0 : word_t'(a << (-c8));
                end else begin
                  v = (c8 >= 15) ? {16{a[15]}} : word_t'($signed(a) >>> c8);
                end
              end
              OP_AND:  v = a & b;
              OP_OR:   v = a | b;
              OP_XOR:  v = a ^ b;
              OP_NOT: begin
                dst = {1'b0, rs};
                v   = ~a;
              end
              OP_SLT:  v = ($signed(a) < $signed(b)) ? 16'd1 : 16'd0;
              OP_LOAD: v = mdl_mem[ls % MEM_WORDS];
              OP_STORE: begin
                wr = 1'b0;
                mdl_mem[ls % MEM_WORDS] = mdl_regs[rd];
                res.mem_written = 1'b1;
              end
              OP_LUI: begin
                dst = {1'b0, rs};
                v   = {c8w[7:0], 8'h00};
              end
              OP_BEQ: begin
                wr = 1'b0;
                if (a == b) mdl_pc = mdl_pc + c4;
              end
              OP_BLT: begin
                wr = 1'b0;
                if ($signed(a) < $signed(b)) mdl_pc = mdl_pc + c4;
              end
              OP_JUMP: begin
                wr = 1'b0;
                mdl_pc = a + c8w;
              end
              default: begin
                // jump and link
                dst = REG_LINK;
                v   = mdl_pc;
                mdl_pc = a + c8w;
              end
            endcase
            // writes to register zero are dropped
            if (wr && dst != REG_ZERO) begin
              mdl_regs[dst] = v;
              res.reg_written = 1'b1;
              res.reg_number  = dst;
              res.reg_value   = v;
            end
          end
        end
      end
    endcase
    res.pc_now = mdl_pc;
    res.halted = mdl_halted;
    return res;
  endfunction

  // offers one transaction with an optional gap, returns at the accepting edge
  task automatic send_item(kind_e kind, word_t addr, word_t data, reg_idx_t ridx,
                           bit typed, result_t typed_res);
    int      gap;
    int      roll;
    result_t pred;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        burst_left = $urandom_range(40, 150);
      end else if (roll < 5) begin
        gap = $urandom_range(20, 60);
      end else if (roll < 30) begin
        gap = $urandom_range(1, 3);
      end
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, ridx, data, addr};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = model_cpu_item(kind, addr, data, ridx);
    cpu_results_due.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (cpu_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name,
                                got, want));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_chk
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o);
      if (cpu_results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none pending", results_seen));
      end else begin
        want = cpu_results_due.pop_front();
        check_field("pc_now", got.pc_now, want.pc_now);
        check_field("instruction", got.instruction, want.instruction);
        check_field("halted", 16'(got.halted), 16'(want.halted));
        check_field("reg_written", 16'(got.reg_written), 16'(want.reg_written));
        check_field("reg_number", 16'(got.reg_number), 16'(want.reg_number));
        check_field("reg_value", got.reg_value, want.reg_value);
        check_field("mem_written", 16'(got.mem_written), 16'(want.mem_written));
        check_field("read_data", got.read_data, want.read_data);
      end
      results_seen++;
    end
  end

  // receiver backpressure: random stalls, free-running stretches, one long hold
  initial begin : sink_ready
    int  stall_left;
    int  free_left;
    int  roll;
    bit  hold_done;
    stall_left = 0;
    free_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
        m_axis_tready_i <= 1'b0;
      end else if (free_left > 0) begin
        free_left--;
        m_axis_tready_i <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          free_left = $urandom_range(30, 120);
          m_axis_tready_i <= 1'b1;
        end else if (roll < 5) begin
          stall_left = $urandom_range(20, 80);
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin : stim
    result_t   typed_res;
    stim_row_t r;
    int        roll;
    bit        paused;
    paused = 1'b0;
    foreach (mdl_mem[i]) mdl_mem[i] = '0;
    foreach (mdl_regs[i]) mdl_regs[i] = '0;
    mdl_pc     = '0;
    mdl_halted = 1'b0;

    // reads and writes before any step, extremes and address wrap
    dir_tab.push_back(stim_row(KIND_READ_MEM, 16'hFFFF, 16'h0000, 5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_READ_REG, 16'h0000, 16'h0000, 5'd31, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'hFFFF, 16'h8000, 5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_READ_MEM, 16'h0FFF, 16'h0000, 5'd0, 1'b1, 16'h0, 16'h8000));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h0FFE, 16'h7FFF, 5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_READ_MEM, 16'hFFFE, 16'h0000, 5'd0, 1'b1, 16'h0, 16'h7FFF));
    // small program: lui, addi, overflow add, large shifts, r0 write, jal, wrapping store
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h1000, enc(OP_LUI, 4'd1, 4'h8, 4'h0),
                               5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h0001, enc(OP_ADDI, 4'd2, 4'hF, 4'hF),
                               5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h0002, enc(OP_ADD, 4'd1, 4'd2, 4'd3),
                               5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h0003, enc(OP_SHIFT, 4'd1, 4'h0, 4'hF),
                               5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h0004, enc(OP_SHIFT, 4'd3, 4'hF, 4'h0),
                               5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h0005, enc(OP_ADD, 4'd1, 4'd2, 4'd0),
                               5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h0006, enc(OP_JAL, 4'd0, 4'h0, 4'h8),
                               5'd0, 1'b1, 16'h0, 16'h0));
    dir_tab.push_back(stim_row(KIND_WRITE_MEM, 16'h0008, enc(OP_STORE, 4'd0, 4'd2, 4'd1),
                               5'd0, 1'b1, 16'h0, 16'h0));
    repeat (8) begin
      dir_tab.push_back(stim_row(KIND_STEP, 16'hFFFF, 16'hFFFF, 5'd31, 1'b0, 16'h0, 16'h0));
    end
    dir_tab.push_back(stim_row(KIND_READ_REG, 16'h0000, 16'h0000, REG_LINK, 1'b0, 16'h0,
                               16'h0));
    dir_tab.push_back(stim_row(KIND_READ_MEM, 16'h0FFF, 16'h0000, 5'd0, 1'b0, 16'h0, 16'h0));

    // reset, released at a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      typed_res = '0;
      typed_res.pc_now    = r.want_pc;
      typed_res.read_data = r.want_read;
      send_item(r.kind, r.addr, r.data, r.ridx, r.typed, typed_res);
    end

    // random programs, never fetching a zero word so the core keeps running
    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent >= PAUSE_AT) begin
        paused = 1'b1;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        if (mdl_mem[mdl_pc % MEM_WORDS] == '0) begin
          send_item(KIND_WRITE_MEM, mdl_pc + word_t'($urandom_range(0, 15) * MEM_WORDS),
                    rand_instr(), reg_idx_t'($urandom_range(0, 31)), 1'b0, '0);
        end
        send_item(KIND_STEP, word_t'($urandom), word_t'($urandom),
                  reg_idx_t'($urandom_range(0, 31)), 1'b0, '0);
      end else if (roll < 75) begin
        send_item(KIND_WRITE_MEM,
                  ($urandom_range(0, 3) == 0) ? word_t'($urandom)
                                              : mdl_pc + word_t'($urandom_range(0, 15)),
                  $urandom_range(0, 1) ? rand_instr() : word_t'($urandom),
                  reg_idx_t'($urandom_range(0, 31)), 1'b0, '0);
      end else if (roll < 87) begin
        send_item(KIND_READ_MEM,
                  $urandom_range(0, 1) ? word_t'($urandom)
                                       : mdl_pc + word_t'($urandom_range(0, 15)),
                  word_t'($urandom), reg_idx_t'($urandom_range(0, 31)), 1'b0, '0);
      end else begin
        send_item(KIND_READ_REG, word_t'($urandom), word_t'($urandom),
                  ($urandom_range(0, 3) == 0) ? reg_idx_t'($urandom_range(17, 31))
                                              : reg_idx_t'($urandom_range(0, 16)),
                  1'b0, '0);
      end
    end

    // halt at the end: zero word fetch, then a step with nothing left to do
    send_item(KIND_WRITE_MEM, mdl_pc, 16'h0000, 5'd0, 1'b0, '0);
    send_item(KIND_STEP, 16'h0000, 16'h0000, 5'd0, 1'b0, '0);
    send_item(KIND_WRITE_MEM, mdl_pc, enc(OP_ADDI, 4'd1, 4'h0, 4'h1), 5'd0, 1'b0, '0);
    send_item(KIND_STEP, 16'h0000, 16'h0000, 5'd0, 1'b0, '0);
    send_item(KIND_READ_REG, 16'h0000, 16'h0000, 5'd1, 1'b0, '0);
    send_item(KIND_READ_MEM, mdl_pc, 16'h0000, 5'd0, 1'b0, '0);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: small_risc_cpu_step.f
rtl/core/smrc_pkg.sv
rtl/core/smrc_wmem.sv
rtl/core/smrc_regfile.sv
rtl/core/smrc_alu.sv
rtl/core/small_risc_cpu_step.sv
dv/tb_small_risc_cpu_step.sv
